// ===== sv/frmh_pkg.sv =====
package frmh_pkg;

	// Number of frame durations held in the averaging ring (4 to 64).
	localparam int unsigned WINDOW_LEN = 64;

	// Field and state widths.
	localparam int unsigned TIME_W = 20;
	localparam int unsigned SUM_W  = 26;
	localparam int unsigned RATE_W = 16;
	localparam int unsigned RUN_W  = 8;
	localparam int unsigned SLOT_W = $clog2(WINDOW_LEN);

	// Dividend of the rate division: WINDOW_LEN frames over one second in microseconds.
	localparam longint unsigned NUMER    = longint'(WINDOW_LEN) * 64'd1000000;
	localparam int unsigned     NUM_W    = $clog2(NUMER + 1);
	localparam logic [NUM_W-1:0] NUMER_V = NUM_W'(NUMER);
	localparam int unsigned     DIV_CNT_W = $clog2(NUM_W);

	// Smallest divisor, hysteresis step and run counter limits.
	localparam logic [SUM_W-1:0]  MIN_SUM   = SUM_W'(1000);
	localparam logic [RATE_W-1:0] STEP_THR  = RATE_W'(3);
	localparam logic [RUN_W-1:0]  RUN_MAX   = RUN_W'(255);
	localparam logic [RUN_W-1:0]  RUN_LIMIT = RUN_W'(WINDOW_LEN / 4);

	// Sequencer states of the top level.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WIN,
		ST_DIV,
		ST_DONE
	} frmh_state_t;

endpackage

// ===== sv/frmh_in_if.sv =====
interface frmh_in_if;
	logic                            valid;
	logic                            ready;
	logic [frmh_pkg::TIME_W-1:0]     frame_time_us;

	modport source (output valid, output frame_time_us, input ready);
	modport sink   (input valid, input frame_time_us, output ready);
endinterface

// ===== sv/frmh_out_if.sv =====
interface frmh_out_if;
	logic                            valid;
	logic                            ready;
	logic [frmh_pkg::RATE_W-1:0]     displayed_rate;
	logic [frmh_pkg::RATE_W-1:0]     average_rate;
	logic                            show;

	modport source (output valid, output displayed_rate, output average_rate, output show,
		input ready);
	modport sink   (input valid, input displayed_rate, input average_rate, input show,
		output ready);
endinterface

// ===== sv/frmh_cfg_if.sv =====
interface frmh_cfg_if;
	logic valid;
	logic ready;
	logic display_enable;

	modport source (output valid, output display_enable, input ready);
	modport sink   (input valid, input display_enable, output ready);
endinterface

// ===== sv/frmh_window.sv =====
module frmh_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        upd,
	input  logic [frmh_pkg::TIME_W-1:0] t_in,
	output logic                        done,
	output logic [frmh_pkg::SUM_W-1:0]  sum
);

	logic [frmh_pkg::TIME_W-1:0]     mem_q [frmh_pkg::WINDOW_LEN];
	logic [frmh_pkg::WINDOW_LEN-1:0] vld_q;
	logic [frmh_pkg::SLOT_W-1:0]     slot_q;
	logic [frmh_pkg::SUM_W-1:0]      sum_q;
	logic                            upd_s1;
	logic                            upd_s2;
	logic                            done_q;
	logic [frmh_pkg::TIME_W-1:0]     old_s1;
	logic                            old_vld_s1;
	logic [frmh_pkg::TIME_W-1:0]     t_s1;
	logic [frmh_pkg::TIME_W-1:0]     t_s2;
	logic [frmh_pkg::TIME_W-1:0]     old_val;

	// Ring storage: the old entry is read in the same cycle as the new one is written.
	always_ff @(posedge clk) begin
		if (upd) begin
			old_s1         <= mem_q[slot_q];
			mem_q[slot_q]  <= t_in;
		end
	end

	// Payload of the update stages.
	always_ff @(posedge clk) begin
		t_s1 <= t_in;
		t_s2 <= t_s1;
	end

	// An entry never written since reset reads as zero.
	assign old_val = old_vld_s1 ? old_s1 : '0;

	// Valid bits, slot pointer, stage flags and the running sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			slot_q     <= '0;
			sum_q      <= '0;
			upd_s1     <= 1'b0;
			upd_s2     <= 1'b0;
			done_q     <= 1'b0;
			old_vld_s1 <= 1'b0;
		end else begin
			upd_s1 <= upd;
			upd_s2 <= upd_s1;
			done_q <= upd_s2;
			if (upd) begin
				old_vld_s1     <= vld_q[slot_q];
				vld_q[slot_q]  <= 1'b1;
				if (slot_q == frmh_pkg::SLOT_W'(frmh_pkg::WINDOW_LEN - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			// The leaving duration is taken off first, the arriving one added next.
			if (upd_s1) begin
				sum_q <= sum_q - {{(frmh_pkg::SUM_W - frmh_pkg::TIME_W){1'b0}}, old_val};
			end
			if (upd_s2) begin
				sum_q <= sum_q + {{(frmh_pkg::SUM_W - frmh_pkg::TIME_W){1'b0}}, t_s2};
			end
		end
	end

	assign done = done_q;
	assign sum  = sum_q;

	// A new update never overlaps one still in flight.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		upd |-> !(upd_s1 || upd_s2 || done_q))
		else $error("window update started while another was in flight");

endmodule

// ===== sv/frmh_div.sv =====
module frmh_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [frmh_pkg::SUM_W-1:0]  divisor,
	output logic                        done,
	output logic [frmh_pkg::RATE_W-1:0] quotient
);

	logic [frmh_pkg::SUM_W-1:0]     div_q;
	logic [frmh_pkg::SUM_W-1:0]     rem_q;
	logic [frmh_pkg::NUM_W-1:0]     nq_q;
	logic [frmh_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [frmh_pkg::SUM_W:0]       shifted;
	logic [frmh_pkg::SUM_W+1:0]     trial;
	logic                           qbit;
	logic [frmh_pkg::SUM_W-1:0]     rem_next;

	// One restoring step: bring down the next dividend bit and try the subtraction.
	always_comb begin
		shifted  = {rem_q, nq_q[frmh_pkg::NUM_W-1]};
		trial    = {1'b0, shifted} - {2'b00, div_q};
		qbit     = !trial[frmh_pkg::SUM_W+1];
		rem_next = qbit ? trial[frmh_pkg::SUM_W-1:0] : shifted[frmh_pkg::SUM_W-1:0];
	end

	// Dividend bits shift out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			nq_q  <= frmh_pkg::NUMER_V;
		end else if (busy_q) begin
			rem_q <= rem_next;
			nq_q  <= {nq_q[frmh_pkg::NUM_W-2:0], qbit};
		end
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == frmh_pkg::DIV_CNT_W'(frmh_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = nq_q[frmh_pkg::RATE_W-1:0];

	// A division is only started when the unit is free.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("division started while busy");

	// With the divisor clamped, the quotient always fits the rate width.
	a_quo_fits: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (nq_q[frmh_pkg::NUM_W-1:frmh_pkg::RATE_W] == '0))
		else $error("quotient exceeds rate width");

endmodule

// ===== sv/frame_rate_meter_hysteresis_unit.sv =====
// Each item passes in order through the ring and sum update, the divider start, the
// bit-serial division (one dividend bit per cycle, 26 dividend bits), the hand-over and
// the output load. A new item is taken only once the previous one has been loaded.
// A result waiting in the output register does not stop the next item being taken, but
// that item's result then waits in ST_DONE and no further item is taken until it is free.
// Reset (arst_n low, asynchronous) empties the ring, clears sum, run count and rates,
// and turns display_enable off; the block is ready at once after reset.
module frame_rate_meter_hysteresis_unit (
	input  logic       clk,
	input  logic       arst_n,
	frmh_in_if.sink    frame_in,
	frmh_out_if.source rate_out,
	frmh_cfg_if.sink   cfg
);

	frmh_pkg::frmh_state_t         state_q;
	frmh_pkg::frmh_state_t         state_next;
	logic                          disp_en_q;
	logic [frmh_pkg::RATE_W-1:0]   prev_avg_q;
	logic [frmh_pkg::RUN_W-1:0]    run_q;
	logic [frmh_pkg::RATE_W-1:0]   shown_q;
	logic                          out_valid_q;
	logic [frmh_pkg::RATE_W-1:0]   out_disp_q;
	logic [frmh_pkg::RATE_W-1:0]   out_avg_q;
	logic                          out_show_q;

	logic                          win_upd;
	logic                          win_done;
	logic [frmh_pkg::SUM_W-1:0]    win_sum;
	logic                          div_start;
	logic                          div_done;
	logic [frmh_pkg::SUM_W-1:0]    div_in;
	logic [frmh_pkg::RATE_W-1:0]   avg;
	logic                          out_load;
	logic [frmh_pkg::RUN_W-1:0]    run_next;
	logic [frmh_pkg::RATE_W-1:0]   gap;
	logic                          take_avg;
	logic [frmh_pkg::RATE_W-1:0]   shown_next;

	frmh_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (win_upd),
		.t_in   (frame_in.frame_time_us),
		.done   (win_done),
		.sum    (win_sum)
	);

	// Short sums are raised to the floor, which also keeps the divisor non-zero.
	assign div_in = (win_sum < frmh_pkg::MIN_SUM) ? frmh_pkg::MIN_SUM : win_sum;

	frmh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (div_in),
		.done     (div_done),
		.quotient (avg)
	);

	// Sequencer: next state and the strobes to the units.
	always_comb begin
		state_next     = state_q;
		win_upd        = 1'b0;
		div_start      = 1'b0;
		out_load       = 1'b0;
		frame_in.ready = 1'b0;
		unique case (state_q)
			frmh_pkg::ST_IDLE: begin
				frame_in.ready = 1'b1;
				if (frame_in.valid) begin
					win_upd    = 1'b1;
					state_next = frmh_pkg::ST_WIN;
				end
			end
			frmh_pkg::ST_WIN: begin
				if (win_done) begin
					div_start  = 1'b1;
					state_next = frmh_pkg::ST_DIV;
				end
			end
			frmh_pkg::ST_DIV: begin
				if (div_done) begin
					state_next = frmh_pkg::ST_DONE;
				end
			end
			frmh_pkg::ST_DONE: begin
				if (!out_valid_q || rate_out.ready) begin
					out_load   = 1'b1;
					state_next = frmh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = frmh_pkg::ST_IDLE;
			end
		endcase
	end

	// Hysteresis: follow the average on a large step or after a long steady run.
	always_comb begin
		if (avg == prev_avg_q) begin
			run_next = (run_q == frmh_pkg::RUN_MAX) ? run_q : run_q + 1'b1;
		end else begin
			run_next = '0;
		end
		gap        = (avg >= shown_q) ? avg - shown_q : shown_q - avg;
		take_avg   = (gap >= frmh_pkg::STEP_THR) || (run_next >= frmh_pkg::RUN_LIMIT);
		shown_next = take_avg ? avg : shown_q;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frmh_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Configuration register, rate history and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_en_q   <= 1'b0;
			prev_avg_q  <= '0;
			run_q       <= '0;
			shown_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				disp_en_q <= cfg.display_enable;
			end
			if (out_load) begin
				prev_avg_q <= avg;
				run_q      <= run_next;
				shown_q    <= shown_next;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rate_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output item register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_disp_q <= shown_next;
			out_avg_q  <= avg;
			out_show_q <= disp_en_q;
		end
	end

	assign cfg.ready               = 1'b1;
	assign rate_out.valid          = out_valid_q;
	assign rate_out.displayed_rate = out_disp_q;
	assign rate_out.average_rate   = out_avg_q;
	assign rate_out.show           = out_show_q;

	// The units only report completion in the state that waits for them.
	a_win_state: assert property (@(posedge clk) disable iff (!arst_n)
		win_done |-> (state_q == frmh_pkg::ST_WIN))
		else $error("window finished outside its wait state");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == frmh_pkg::ST_DIV))
		else $error("divider finished outside its wait state");

endmodule

// ===== tb/frame_rate_meter_hysteresis_unit_tb.sv =====
module frame_rate_meter_hysteresis_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned SETTLE_TICKS = 40;
	localparam int unsigned PHASE_ITEMS  = 270;
	localparam int unsigned STEADY_ITEMS = 350;

	// Directed frames: start-up with an empty ring, clamped sums, field extremes,
	// large jumps and small moves around a steady rate.
	localparam logic [frmh_pkg::TIME_W-1:0] DIRECTED_TIMES [21] = '{
		20'd0, 20'd0, 20'd1, 20'd999, 20'd1000, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
		20'd0, 20'd524288, 20'd16667, 20'd16667, 20'd16666, 20'd16668, 20'd16667,
		20'd33333, 20'd8333, 20'd1, 20'hFFFFF, 20'hAAAAA, 20'h55555};

	typedef struct packed {
		logic [frmh_pkg::RATE_W-1:0] displayed;
		logic [frmh_pkg::RATE_W-1:0] average;
		logic                        show;
	} rate_result_t;

	logic clk;
	logic arst_n;

	frmh_in_if  frame_in();
	frmh_out_if rate_out();
	frmh_cfg_if cfg();

	frame_rate_meter_hysteresis_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame_in (frame_in),
		.rate_out (rate_out),
		.cfg      (cfg)
	);

	// Frame durations waiting to be sent, and the rates they should produce.
	logic [frmh_pkg::TIME_W-1:0] pending_times[$];
	rate_result_t                awaited_rates[$];
	rate_result_t                oldest_rate;

	// Own copy of the meter state.
	logic [frmh_pkg::TIME_W-1:0] ring_times[frmh_pkg::WINDOW_LEN];
	logic [frmh_pkg::SUM_W-1:0]  ring_sum;
	logic [frmh_pkg::SLOT_W-1:0] ring_slot;
	logic [frmh_pkg::RATE_W-1:0] last_avg;
	logic [frmh_pkg::RUN_W-1:0]  repeat_run;
	logic [frmh_pkg::RATE_W-1:0] held_rate;
	logic                        shown_enable;

	int unsigned errors;
	int unsigned frames_sent;
	int unsigned results_checked;
	int unsigned cfg_writes;
	int unsigned floor_hits;
	int unsigned sat_hits;
	int unsigned quiet_ticks;
	bit          calm;

	always #6 clk = ~clk;

	// Advances the meter by one frame duration and returns the rates it shows.
	function automatic rate_result_t advance_meter(input logic [frmh_pkg::TIME_W-1:0] t);
		logic [frmh_pkg::SLOT_W-1:0] slot;
		logic [frmh_pkg::SUM_W-1:0]  divisor;
		longint unsigned             quotient;
		logic [frmh_pkg::RATE_W-1:0] avg;
		int                          a;
		int                          s;
		rate_result_t                r;
		slot = ring_slot;
		ring_sum = ring_sum - ring_times[slot] + t;
		ring_times[slot] = t;
		ring_slot = (slot == frmh_pkg::SLOT_W'(frmh_pkg::WINDOW_LEN - 1)) ? '0 : slot + 1'b1;

		// A short window sum is clamped, which also keeps the divisor non-zero.
		if (ring_sum < frmh_pkg::MIN_SUM) begin
			divisor = frmh_pkg::MIN_SUM;
			floor_hits++;
		end else begin
			divisor = ring_sum;
		end
		quotient = frmh_pkg::NUMER / longint'(divisor);
		avg = quotient[frmh_pkg::RATE_W-1:0];

		// The repeat counter saturates instead of wrapping.
		if (avg == last_avg) begin
			if (repeat_run < frmh_pkg::RUN_MAX)
				repeat_run++;
			else
				sat_hits++;
		end else begin
			repeat_run = '0;
		end
		last_avg = avg;

		// Hysteresis: follow a large move at once, a small one only once it has settled.
		a = int'(avg);
		s = int'(held_rate);
		if (a <= s - int'(frmh_pkg::STEP_THR) || a >= s + int'(frmh_pkg::STEP_THR) ||
				repeat_run >= frmh_pkg::RUN_LIMIT)
			held_rate = avg;

		r.displayed = held_rate;
		r.average   = avg;
		r.show      = shown_enable;
		return r;
	endfunction

	// Item driver: holds an item until it is taken, idles at random between items.
	always @(posedge clk) begin
		if (arst_n) begin
			if (frame_in.valid && frame_in.ready) begin
				awaited_rates.insert(awaited_rates.size(),
					advance_meter(frame_in.frame_time_us));
				frames_sent++;
			end
			if (!frame_in.valid || frame_in.ready) begin
				if (pending_times.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
					frame_in.valid         <= 1'b1;
					frame_in.frame_time_us <= pending_times.pop_front();
				end else begin
					frame_in.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each result against the oldest awaited one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rate_out.valid && rate_out.ready) begin
				if (awaited_rates.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %0d/%0d/%0b",
						$time, rate_out.displayed_rate, rate_out.average_rate, rate_out.show);
				end else begin
					oldest_rate = awaited_rates.pop_front();
					results_checked++;
					if (rate_out.displayed_rate !== oldest_rate.displayed) begin
						errors++;
						$display("%0t: displayed_rate expected %0d actual %0d", $time,
							oldest_rate.displayed, rate_out.displayed_rate);
					end
					if (rate_out.average_rate !== oldest_rate.average) begin
						errors++;
						$display("%0t: average_rate expected %0d actual %0d", $time,
							oldest_rate.average, rate_out.average_rate);
					end
					if (rate_out.show !== oldest_rate.show) begin
						errors++;
						$display("%0t: show expected %0b actual %0b", $time,
							oldest_rate.show, rate_out.show);
					end
				end
			end
			rate_out.ready <= calm || ($urandom_range(99) >= 31);
		end
	end

	// Watchdog: ends the run if no channel moves an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((frame_in.valid && frame_in.ready) || (rate_out.valid && rate_out.ready) ||
					(cfg.valid && cfg.ready)) begin
				quiet_ticks <= 0;
			end else if (quiet_ticks >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, quiet_ticks);
				$display("== FAIL ==");
				$finish;
			end else begin
				quiet_ticks <= quiet_ticks + 1;
			end
		end
	end

	// Waits until every item has been sent and every result has come back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_times.size() != 0 || frame_in.valid || awaited_rates.size() != 0);
	endtask

	// Writes the display-enable register; only called while the block is idle.
	task automatic write_display_enable(input logic v);
		repeat (4) @(posedge clk);
		cfg.valid          <= 1'b1;
		cfg.display_enable <= v;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid    <= 1'b0;
		shown_enable = v;
		cfg_writes++;
		@(negedge clk);
	endtask

	// Queues a phase of frame durations built from short segments of typical traffic:
	// steady rates, jitter, drifting rates, tiny and huge frames, and plain noise.
	task automatic queue_random_phase(input int unsigned target, input bit long_steady);
		int unsigned                 n;
		int unsigned                 len;
		int unsigned                 kind;
		logic [frmh_pkg::TIME_W-1:0] base;
		logic [frmh_pkg::TIME_W-1:0] t;
		n = 0;
		while (n < target) begin
			kind = $urandom_range(9);
			len  = $urandom_range(8, 90);
			if ($urandom_range(15) == 0)
				len = 340;
			base = frmh_pkg::TIME_W'($urandom_range(2000, 60000));
			// A long constant stretch drives the repeat counter into saturation.
			if (long_steady && n == 0) begin
				kind = 0;
				len  = 340;
			end
			for (int unsigned k = 0; k < len && n < target; k++) begin
				case (kind)
					0, 1, 2, 3: begin
						t = base;
					end
					4, 5: begin
						t = frmh_pkg::TIME_W'(int'(base) + int'($urandom_range(400)) - 200);
					end
					6: begin
						t = frmh_pkg::TIME_W'($urandom_range(40));
					end
					7: begin
						t = frmh_pkg::TIME_W'($urandom());
					end
					8: begin
						t = frmh_pkg::TIME_W'($urandom_range(500000, 1048575));
					end
					default: begin
						t = frmh_pkg::TIME_W'(int'(base) + int'(k) * 37);
					end
				endcase
				pending_times.insert(pending_times.size(), t);
				n++;
			end
		end
	endtask

	initial begin
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		frame_in.valid         = 1'b0;
		frame_in.frame_time_us = '0;
		rate_out.ready         = 1'b0;
		cfg.valid              = 1'b0;
		cfg.display_enable     = 1'b0;
		calm                   = 1'b0;
		quiet_ticks            = 0;
		foreach (ring_times[i])
			ring_times[i] = '0;
		ring_sum     = '0;
		ring_slot    = '0;
		last_avg     = '0;
		repeat_run   = '0;
		held_rate    = '0;
		shown_enable = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_display_enable(1'b1);

		foreach (DIRECTED_TIMES[i])
			pending_times.insert(pending_times.size(), DIRECTED_TIMES[i]);
		wait_drained();

		// Random phases with the enable rewritten before each; the third runs without idling.
		for (int p = 0; p < 5; p++) begin
			write_display_enable((p == 1 || p == 2 || p == 4) ? 1'b1 : 1'b0);
			calm = (p == 2);
			queue_random_phase((p == 2) ? STEADY_ITEMS : PHASE_ITEMS, p == 2);
			wait_drained();
			calm = 1'b0;
		end

		repeat (SETTLE_TICKS) @(posedge clk);
		$display("Sent %0d frame durations and checked %0d results over %0d enable writes.",
			frames_sent, results_checked, cfg_writes);
		$display("Sum below the floor on %0d frames; repeat counter held at its limit %0d times.",
			floor_hits, sat_hits);
		if (errors == 0 && awaited_rates.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/frmh_pkg.sv
sv/frmh_in_if.sv
sv/frmh_out_if.sv
sv/frmh_cfg_if.sv
sv/frmh_window.sv
sv/frmh_div.sv
sv/frame_rate_meter_hysteresis_unit.sv
tb/frame_rate_meter_hysteresis_unit_tb.sv
